/* rtl/hrlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_pkg
// Types, character constants and match helpers for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DOT = 8'h2E;

  localparam int unsigned NUM_EXT = 5;

  typedef enum logic [1:0] {
    METHOD_UNKNOWN = 2'd0,
    METHOD_GET     = 2'd1,
    METHOD_POST    = 2'd2
  } method_e;

  typedef enum logic [2:0] {
    EXT_UNKNOWN = 3'd0,
    EXT_HTML    = 3'd1,
    EXT_CSS     = 3'd2,
    EXT_JS      = 3'd3,
    EXT_JPG     = 3'd4,
    EXT_ICO     = 3'd5
  } ext_e;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_METHOD = 5'b00010,
    PH_NAME   = 5'b00100,
    PH_REST   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  // Padded with NUL so a two-bit index never leaves the table.
  localparam logic [7:0] GET_TEXT  [4] = '{"G", "E", "T", 8'h00};
  localparam logic [7:0] POST_TEXT [4] = '{"P", "O", "S", "T"};

  localparam logic [7:0] EXT_TEXT [NUM_EXT][4] = '{
    '{"h", "t", "m", "l"},
    '{"c", "s", "s", 8'h00},
    '{"j", "s", 8'h00, 8'h00},
    '{"j", "p", "g", 8'h00},
    '{"i", "c", "o", 8'h00}
  };
  localparam logic [2:0] EXT_LEN [NUM_EXT] = '{3'd4, 3'd3, 3'd2, 3'd3, 3'd3};

  typedef struct packed {
    logic [5:0]         len;
    logic               dot;
    logic [2:0]         ext_pos;
    logic [NUM_EXT-1:0] ext_flags;
  } name_t;

  localparam name_t NAME_CLEAR = '{len: 6'd0, dot: 1'b0, ext_pos: 3'd0,
                                   ext_flags: {NUM_EXT{1'b1}}};

  typedef struct packed {
    logic       filename_valid;
    logic [7:0] filename_char;
    logic       line_done;
    logic [1:0] method_code;
    logic [2:0] extension_code;
    logic [5:0] filename_length;
  } result_t;

  // Counts one filename byte and advances the extension match.
  function automatic name_t take_name_byte(name_t n, logic [7:0] c);
    name_t r;
    r = n;
    if (n.len != 6'd63) r.len = n.len + 6'd1;
    if (!n.dot) begin
      if (c == CH_DOT) r.dot = 1'b1;
    end else if (n.ext_pos >= 3'd4) begin
      r.ext_flags = '0;
      r.ext_pos   = 3'd5;
    end else begin
      for (int k = 0; k < NUM_EXT; k++) begin
        if (!(n.ext_pos < EXT_LEN[k] && c == EXT_TEXT[k][n.ext_pos[1:0]])) begin
          r.ext_flags[k] = 1'b0;
        end
      end
      r.ext_pos = n.ext_pos + 3'd1;
    end
    return r;
  endfunction

  // Lowest matching candidate wins.
  function automatic logic [2:0] ext_code(name_t n);
    logic [2:0] code;
    code = EXT_UNKNOWN;
    if (n.dot) begin
      for (int k = NUM_EXT - 1; k >= 0; k--) begin
        if (n.ext_flags[k] && n.ext_pos == EXT_LEN[k]) code = 3'(k + 1);
      end
    end
    return code;
  endfunction

endpackage

/* rtl/hrlp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_if
// Valid/ready channels for header bytes in and parse results out.
// ----------------------------------------------------------------------------
interface hrlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface hrlp_result_if;
  logic       valid;
  logic       ready;
  logic       filename_valid;
  logic [7:0] filename_char;
  logic       line_done;
  logic [1:0] method_code;
  logic [2:0] extension_code;
  logic [5:0] filename_length;

  modport source (output valid, filename_valid, filename_char, line_done, method_code,
                  extension_code, filename_length, input ready);
  modport sink   (input valid, filename_valid, filename_char, line_done, method_code,
                  extension_code, filename_length, output ready);
endinterface

/* rtl/http_request_line_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_parser
// Parses the first request line of a header byte stream: method, filename
// bytes, extension and filename length. One result item per byte item.
// ----------------------------------------------------------------------------
//  channel | dir | modport | carries
//  --------+-----+---------+------------------------------------------------
//  req_i   | in  | sink    | data_byte, first_byte, last_byte
//  res_o   | out | source  | filename_valid/char, line_done, method, ext, len
//
//  One item per clock while req_i is ready; its result is registered in the
//  output register, or in the skid register when the output is stalled.
//  Parse state updates at accept; the result lands in an output register
//  backed by a one-entry skid register, so req_i stays ready while a result
//  waits and only drops when both are full.
//  Reset clears the parser to waiting for a first byte and empties the output.
module http_request_line_parser
  import hrlp_pkg::*;
#(
  parameter int unsigned HEAD_LIMIT   = 64,
  parameter int unsigned METHOD_LIMIT = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hrlp_byte_if.sink     req_i,
  hrlp_result_if.source res_o
);

  localparam int unsigned POS_MAX = (HEAD_LIMIT > METHOD_LIMIT) ? HEAD_LIMIT : METHOD_LIMIT;
  localparam int unsigned POS_W   = $clog2(POS_MAX + 1);

  // parse state
  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       mflags_q, mflags_d;
  logic [1:0]       method_q, method_d;
  name_t            name_q, name_d;
  logic [2:0]       ext_q, ext_d;
  logic             cr_pending_q, cr_pending_d;
  logic             held_valid_q, held_valid_d;
  logic [7:0]       held_char_q, held_char_d;

  result_t res;
  logic    accept;
  logic    line_end;
  logic [7:0] c;

  // output stage
  logic    main_v_q, skid_v_q;
  result_t main_q, skid_q;

  assign c      = req_i.data_byte;
  assign accept = req_i.valid && req_i.ready;

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    mflags_d     = mflags_q;
    method_d     = method_q;
    name_d       = name_q;
    ext_d        = ext_q;
    cr_pending_d = cr_pending_q;
    held_valid_d = held_valid_q;
    held_char_d  = held_char_q;
    res          = '0;
    line_end     = 1'b0;

    if (req_i.first_byte) begin
      phase_d      = PH_METHOD;
      pos_d        = '0;
      mflags_d     = 2'b11;
      method_d     = METHOD_UNKNOWN;
      name_d       = NAME_CLEAR;
      ext_d        = EXT_UNKNOWN;
      cr_pending_d = 1'b0;
      held_valid_d = 1'b0;
      held_char_d  = '0;
    end

    if (phase_d == PH_METHOD || phase_d == PH_NAME || phase_d == PH_REST) begin
      line_end = cr_pending_d && c == CH_LF;
      // A held byte goes out with the result of the byte after it; a CR that starts CR LF is dropped.
      if (held_valid_d) begin
        if (!(line_end && held_char_d == CH_CR)) begin
          res.filename_valid = 1'b1;
          res.filename_char  = held_char_d;
          if (held_char_d == CH_CR) name_d = take_name_byte(name_d, CH_CR);
        end
        held_valid_d = 1'b0;
      end
      cr_pending_d = (c == CH_CR);

      if (line_end) begin
        if (phase_d == PH_NAME) ext_d = ext_code(name_d);
        res.line_done   = 1'b1;
        res.method_code = method_d;
        if (method_d != METHOD_UNKNOWN) begin
          res.extension_code  = ext_d;
          res.filename_length = name_d.len;
        end
        phase_d = PH_DONE;
      end else if (phase_d == PH_METHOD) begin
        if (pos_d >= POS_W'(METHOD_LIMIT)) begin
          phase_d = PH_REST;
        end else if (c == CH_SP) begin
          if (mflags_d[0] && pos_d == POS_W'(3)) method_d = METHOD_GET;
          else if (mflags_d[1] && pos_d == POS_W'(4)) method_d = METHOD_POST;
          phase_d = (method_d != METHOD_UNKNOWN) ? PH_NAME : PH_REST;
        end else begin
          if (!(pos_d < POS_W'(3) && c == GET_TEXT[pos_d[1:0]])) mflags_d[0] = 1'b0;
          if (!(pos_d < POS_W'(4) && c == POST_TEXT[pos_d[1:0]])) mflags_d[1] = 1'b0;
        end
      end else if (phase_d == PH_NAME) begin
        if (pos_d >= POS_W'(HEAD_LIMIT)) begin
          name_d.len = '0;
          ext_d      = EXT_UNKNOWN;
          phase_d    = PH_REST;
        end else if (c == CH_SP) begin
          ext_d   = ext_code(name_d);
          phase_d = PH_REST;
        end else begin
          held_valid_d = 1'b1;
          held_char_d  = c;
          if (c != CH_CR) name_d = take_name_byte(name_d, c);
        end
      end

      if (pos_d != POS_W'(POS_MAX)) pos_d = pos_d + POS_W'(1);

      if (req_i.last_byte && phase_d != PH_DONE) begin
        res.line_done       = 1'b1;
        res.method_code     = METHOD_UNKNOWN;
        res.extension_code  = EXT_UNKNOWN;
        res.filename_length = '0;
        phase_d             = PH_DONE;
      end
      if (phase_d == PH_DONE) held_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      pos_q        <= '0;
      mflags_q     <= 2'b11;
      method_q     <= METHOD_UNKNOWN;
      name_q       <= NAME_CLEAR;
      ext_q        <= EXT_UNKNOWN;
      cr_pending_q <= 1'b0;
      held_valid_q <= 1'b0;
      held_char_q  <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      mflags_q     <= mflags_d;
      method_q     <= method_d;
      name_q       <= name_d;
      ext_q        <= ext_d;
      cr_pending_q <= cr_pending_d;
      held_valid_q <= held_valid_d;
      held_char_q  <= held_char_d;
    end
  end

  // Output register with skid entry.
  assign req_i.ready = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!main_v_q || res_o.ready) begin
      if (skid_v_q) begin
        main_v_q <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= accept;
      end
    end else if (accept) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_v_q || res_o.ready) begin
      if (skid_v_q) main_q <= skid_q;
      else if (accept) main_q <= res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign res_o.valid           = main_v_q;
  assign res_o.filename_valid  = main_q.filename_valid;
  assign res_o.filename_char   = main_q.filename_char;
  assign res_o.line_done       = main_q.line_done;
  assign res_o.method_code     = main_q.method_code;
  assign res_o.extension_code  = main_q.extension_code;
  assign res_o.filename_length = main_q.filename_length;

  // Assertions
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry holds an item while the output register is empty");

  a_done_closes_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res.line_done) |=> phase_q == PH_DONE)
    else $error("line finished but parser did not move to done");

  a_held_needs_method: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (method_q == METHOD_GET || method_q == METHOD_POST))
    else $error("filename byte held without a recognized method");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_v_q && skid_v_q && !res_o.ready) |=> main_v_q && skid_v_q)
    else $error("stalled output lost an item");

endmodule
